FILE: hw/rtl/stp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package stp_pkg;

  localparam int COUNT_BITS_DEF = 16;
  localparam int END_W          = 16;
  localparam int VALUE_W        = 64;
  localparam int RADIX_W        = 6;
  localparam int DIGIT_W        = 7;

  localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
  localparam logic [RADIX_W-1:0] RADIX_AUTO  = 6'd0;
  localparam logic [RADIX_W-1:0] RADIX_DEC   = 6'd10;
  localparam logic [RADIX_W-1:0] RADIX_HEX   = 6'd16;
  localparam logic [RADIX_W-1:0] RADIX_OCT   = 6'd8;

  localparam logic [2:0] PH_SPACE  = 3'd0;
  localparam logic [2:0] PH_SIGNED = 3'd1;
  localparam logic [2:0] PH_PREFIX = 3'd2;
  localparam logic [2:0] PH_DIGITS = 3'd3;
  localparam logic [2:0] PH_DONE   = 3'd4;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;
  localparam logic [7:0] CH_UX    = 8'h58;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LF    = 8'h66;
  localparam logic [7:0] CH_LX    = 8'h78;

  localparam logic [DIGIT_W-1:0] DIGIT_NONE = 7'd99;

  typedef struct packed {
    logic [2:0]         phase;
    logic               neg;
    logic [RADIX_W-1:0] radix;
    logic [VALUE_W-1:0] acc;
  } stp_state_t;

  localparam stp_state_t STATE_CLEAR = '{
    phase: PH_SPACE,
    neg:   1'b0,
    radix: '0,
    acc:   '0
  };

  // Digit value of a character, DIGIT_NONE when it is not a hex digit.
  function automatic logic [DIGIT_W-1:0] digit_of(input logic [7:0] c);
    logic [7:0] d;
    begin
      d = {1'b0, DIGIT_NONE};
      if (c >= CH_ZERO && c <= CH_NINE) begin
        d = c - CH_ZERO;
      end else if (c >= CH_LA && c <= CH_LF) begin
        d = c - CH_LA + 8'd10;
      end else if (c >= CH_UA && c <= CH_UF) begin
        d = c - CH_UA + 8'd10;
      end
      digit_of = d[DIGIT_W-1:0];
    end
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/stp_step.sv
`timescale 1ns / 1ps
`default_nettype none

module stp_step
  import stp_pkg::*;
(
  input  stp_state_t         st,
  input  logic [7:0]         ch,
  input  logic [RADIX_W-1:0] cfg_radix,
  output stp_state_t         st_nxt,
  output logic               bump,
  output logic               emit,
  output logic [VALUE_W-1:0] value
);

  logic [DIGIT_W-1:0] dig;
  logic               held;
  stp_state_t         s;

  assign dig   = digit_of(ch);
  assign emit  = (ch == CH_NUL);
  assign value = st.neg ? (VALUE_W'(0) - st.acc) : st.acc;

  always_comb begin
    s    = st;
    bump = 1'b0;
    held = 1'b0;
    if (ch == CH_NUL) begin
      s = STATE_CLEAR;
    end else begin
      if (s.phase == PH_SPACE) begin
        s.radix = cfg_radix;
        if (ch inside {CH_SPACE, CH_TAB}) begin
          bump = 1'b1;
          held = 1'b1;
        end else if (ch inside {CH_PLUS, CH_MINUS}) begin
          s.neg   = (ch == CH_MINUS);
          bump    = 1'b1;
          held    = 1'b1;
          s.phase = PH_SIGNED;
        end else begin
          s.phase = PH_SIGNED;
        end
      end

      if (!held && s.phase == PH_SIGNED) begin
        if (s.radix == RADIX_AUTO) begin
          if (ch == CH_ZERO) begin
            bump    = 1'b1;
            held    = 1'b1;
            s.phase = PH_PREFIX;
          end else begin
            s.radix = RADIX_DEC;
          end
        end
        if (!held) begin
          s.phase = PH_DIGITS;
        end
      end

      if (!held && s.phase == PH_PREFIX) begin
        if (ch inside {CH_LX, CH_UX}) begin
          s.radix = RADIX_HEX;
          bump    = 1'b1;
          held    = 1'b1;
        end else begin
          s.radix = RADIX_OCT;
        end
        s.phase = PH_DIGITS;
      end

      // multiply-add by the active radix, or stop on a non-digit
      if (!held && s.phase == PH_DIGITS) begin
        if (dig >= DIGIT_W'(s.radix)) begin
          s.phase = PH_DONE;
        end else begin
          s.acc = s.acc * VALUE_W'(s.radix) + VALUE_W'(dig);
          bump  = 1'b1;
        end
      end
    end
    st_nxt = s;
  end

endmodule

`default_nettype wire

FILE: hw/rtl/string_to_integer_parser.sv
// Streaming signed integer parser, one string character per request.
// Input channel: in_valid / in_stall with in_char_code. A zero byte ends the
// string and produces one result; every other byte produces none.
// Result channel: out_valid / out_stall with out_value (64-bit two's
// complement, wraps on overflow) and out_end_position (characters consumed,
// saturating).
// cfg_wr_en / cfg_wr_data load the radix (0 = detect from prefix); write it
// only while no string is in flight.
// Throughput: one character per cycle while in_stall is low. The multiply-add
// of the accumulator by the radix and the digit sits between the input register
// and the state registers, so each character that is not held by in_stall is
// fully absorbed in the cycle after it is taken.
// A terminating zero byte passes through the input register and then the
// result register before it shows on out_valid.
// Stall: the output register holds its result while out_stall is high;
// characters keep flowing, and only a terminating byte that finds the
// result register still occupied backs up into in_stall.
// Reset: clears the parse state, empties both registers and sets the
// radix to 10.
`timescale 1ns / 1ps
`default_nettype none

module string_to_integer_parser
  import stp_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_wr_en,
  input  logic [RADIX_W-1:0]        cfg_wr_data,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [7:0]                in_char_code,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [VALUE_W-1:0] out_value,
  output logic [END_W-1:0]          out_end_position
);

  localparam int CNT_W = (COUNT_BITS < END_W) ? COUNT_BITS : END_W;

  logic [RADIX_W-1:0] radix_r;
  logic               in_vld_r;
  logic [7:0]         in_char_r;
  stp_state_t         st_r;
  stp_state_t         st_nxt;
  logic [CNT_W-1:0]   cnt_r;
  logic [CNT_W-1:0]   cnt_nxt;
  logic               out_vld_r;
  logic [VALUE_W-1:0] out_value_r;
  logic [END_W-1:0]   out_end_r;

  logic               bump;
  logic               emit;
  logic [VALUE_W-1:0] value;
  logic               adv;
  logic               fire;

  stp_step u_step (
    .st        (st_r),
    .ch        (in_char_r),
    .cfg_radix (radix_r),
    .st_nxt    (st_nxt),
    .bump      (bump),
    .emit      (emit),
    .value     (value)
  );

  // a character advances unless it is a terminator facing a full, stalled result
  assign adv      = in_vld_r && (!emit || !out_vld_r || !out_stall);
  assign fire     = adv && emit;
  assign in_stall = in_vld_r && !adv;

  always_comb begin
    cnt_nxt = cnt_r;
    if (emit) begin
      cnt_nxt = '0;
    end else if (bump && cnt_r != {CNT_W{1'b1}}) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r <= RADIX_RESET;
    end else if (cfg_wr_en) begin
      radix_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (!in_stall) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      in_char_r <= in_char_code;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= STATE_CLEAR;
      cnt_r <= '0;
    end else if (adv) begin
      st_r  <= st_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (fire) begin
      out_vld_r <= 1'b1;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_value_r <= value;
      out_end_r   <= END_W'(cnt_r);
    end
  end

  assign out_valid        = out_vld_r;
  assign out_value        = out_value_r;
  assign out_end_position = out_end_r;

  // a terminator clears the parse state and raises a result
  a_nul_clears: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_vld_r && cnt_r == '0 && st_r.phase == PH_SPACE && st_r.acc == '0)
    else $error("terminator did not clear state or raise result");

  // back-pressure only ever comes from a waiting terminator
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> in_vld_r && in_char_r == CH_NUL && out_vld_r && out_stall)
    else $error("input stalled without a blocked terminator");

  // after the stop, characters leave the accumulator and count alone
  a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
    adv && !emit && st_r.phase == PH_DONE |=> $stable(st_r.acc) && $stable(cnt_r))
    else $error("state changed after parsing stopped");

endmodule

`default_nettype wire

FILE: verif/string_to_integer_parser_test.sv
`timescale 1ns / 1ps

module string_to_integer_parser_test;
  import stp_pkg::*;

  localparam int COUNT_BITS = COUNT_BITS_DEF;
  localparam logic [END_W-1:0] COUNT_LIMIT =
    (COUNT_BITS >= END_W) ? {END_W{1'b1}} : END_W'((1 << COUNT_BITS) - 1);
  localparam int PHASE_CHARS = 170;
  localparam int HOLD_OFF_CYCLES = 300;

  typedef struct {
    logic [VALUE_W-1:0] value;
    logic [END_W-1:0]   end_pos;
  } parsed_number_t;

  class parse_scoreboard;
    logic [RADIX_W-1:0] radix;
    logic [2:0]         phase;
    logic               neg;
    logic [RADIX_W-1:0] base;
    logic [VALUE_W-1:0] acc;
    logic [END_W-1:0]   consumed;
    parsed_number_t     expected_numbers[$];
    int                 mismatches;

    function new();
      radix = RADIX_RESET;
      mismatches = 0;
      restart();
    endfunction

    function void restart();
      phase = PH_SPACE;
      neg = 1'b0;
      base = '0;
      acc = '0;
      consumed = '0;
    endfunction

    function void count_one();
      if (consumed != COUNT_LIMIT) consumed++;
    endfunction

    function logic [DIGIT_W-1:0] digit_value(logic [7:0] c);
      if (c >= CH_ZERO && c <= CH_NINE) return c[6:0] - CH_ZERO[6:0];
      if (c >= CH_LA && c <= CH_LF) return c[6:0] - CH_LA[6:0] + 7'd10;
      if (c >= CH_UA && c <= CH_UF) return c[6:0] - CH_UA[6:0] + 7'd10;
      return DIGIT_NONE;
    endfunction

    function int pending();
      return expected_numbers.size();
    endfunction

    // Advance the parse by one accepted request; returns 0 when the byte is ignored.
    function bit take_char(logic [7:0] c);
      parsed_number_t num;
      logic [DIGIT_W-1:0] d;
      if (c == CH_NUL) begin
        num.value = neg ? -acc : acc;
        num.end_pos = consumed;
        expected_numbers.push_back(num);
        restart();
        return 1'b1;
      end
      if (phase > PH_DIGITS) return 1'b0;
      if (phase == PH_SPACE) begin
        base = radix;
        if (c == CH_SPACE || c == CH_TAB) begin
          count_one();
          return 1'b1;
        end
        if (c == CH_PLUS || c == CH_MINUS) begin
          neg = (c == CH_MINUS);
          count_one();
          phase = PH_SIGNED;
          return 1'b1;
        end
        phase = PH_SIGNED;
      end
      if (phase == PH_SIGNED) begin
        if (base == RADIX_AUTO) begin
          if (c == CH_ZERO) begin
            count_one();
            phase = PH_PREFIX;
            return 1'b1;
          end
          base = RADIX_DEC;
        end
        phase = PH_DIGITS;
      end
      if (phase == PH_PREFIX) begin
        if (c == CH_LX || c == CH_UX) begin
          base = RADIX_HEX;
          count_one();
          phase = PH_DIGITS;
          return 1'b1;
        end
        base = RADIX_OCT;
        phase = PH_DIGITS;
      end
      d = digit_value(c);
      if (d >= base) begin
        phase = PH_DONE;
      end else begin
        acc = acc * base + d;
        count_one();
      end
      return 1'b1;
    endfunction

    function void compare_number(logic [VALUE_W-1:0] value, logic [END_W-1:0] end_pos);
      parsed_number_t num;
      if (expected_numbers.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: unexpected result value %h end_position %0d", value, end_pos);
        return;
      end
      num = expected_numbers.pop_front();
      if (num.value !== value || num.end_pos !== end_pos) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: value exp %h got %h, end_position exp %0d got %0d",
                   num.value, value, num.end_pos, end_pos);
      end
    endfunction
  endclass

  logic                      clk = 1'b0;
  logic                      rst_n;
  logic                      cfg_wr_en;
  logic [RADIX_W-1:0]        cfg_wr_data;
  logic                      in_valid;
  logic                      in_stall;
  logic [7:0]                in_char_code;
  logic                      out_valid;
  logic                      out_stall;
  logic signed [VALUE_W-1:0] out_value;
  logic [END_W-1:0]          out_end_position;

  parse_scoreboard sb;
  logic [7:0] str_q[$];
  int send_idle_max;
  int recv_idle_max;
  int pressure_req;
  int live_chars;

  string_to_integer_parser #(
    .COUNT_BITS(COUNT_BITS)
  ) uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_char_code     (in_char_code),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_value        (out_value),
    .out_end_position (out_end_position)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // Result side: draw a stall after each result, and hold off on request.
  initial begin
    int stall_left;
    int hold_left;
    int pressure_seen;
    stall_left = 0;
    hold_left = 0;
    pressure_seen = 0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        sb.compare_number(out_value, out_end_position);
        stall_left = $urandom_range(0, recv_idle_max);
      end
      @(negedge clk);
      if (pressure_req != pressure_seen) begin
        pressure_seen = pressure_req;
        hold_left = HOLD_OFF_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic push_char(input logic [7:0] c);
    int gap;
    gap = $urandom_range(0, send_idle_max);
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_char_code <= c;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (sb.take_char(c)) live_chars++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) push_char(s[i]);
    push_char(CH_NUL);
  endtask

  task automatic send_str_q();
    foreach (str_q[i]) push_char(str_q[i]);
    push_char(CH_NUL);
  endtask

  // Drop valid and wait until every result is back and the block is quiet.
  task automatic drain_requests();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_radix(input logic [RADIX_W-1:0] r);
    drain_requests();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= r;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    sb.radix = r;
  endtask

  function automatic logic [7:0] digit_char(int v);
    if (v < 10) return CH_ZERO + 8'(v);
    if ($urandom_range(0, 1)) return CH_LA + 8'(v - 10);
    return CH_UA + 8'(v - 10);
  endfunction

  // Blanks, optional sign, prefix under auto radix, digits and maybe a stop tail.
  task automatic build_number(input logic [RADIX_W-1:0] r);
    int b;
    int maxd;
    int len;
    int sel;
    str_q.delete();
    repeat ($urandom_range(0, 3)) str_q.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
    sel = $urandom_range(0, 2);
    if (sel == 1) str_q.push_back(CH_PLUS);
    if (sel == 2) str_q.push_back(CH_MINUS);
    b = r;
    if (r == RADIX_AUTO) begin
      sel = $urandom_range(0, 2);
      if (sel == 0) begin
        str_q.push_back(CH_ZERO);
        str_q.push_back($urandom_range(0, 1) ? CH_LX : CH_UX);
        b = 16;
      end else if (sel == 1) begin
        str_q.push_back(CH_ZERO);
        b = 8;
      end else begin
        b = 10;
      end
    end
    maxd = (b > 16) ? 16 : b;
    len = ($urandom_range(0, 7) == 0) ? $urandom_range(12, 30) : $urandom_range(0, 6);
    if (maxd > 0)
      repeat (len) str_q.push_back(digit_char($urandom_range(0, maxd - 1)));
    if ($urandom_range(0, 2) == 0)
      repeat ($urandom_range(1, 4)) str_q.push_back(8'($urandom_range(1, 255)));
  endtask

  task automatic build_noise();
    logic [7:0] specials[10];
    specials = '{CH_SPACE, CH_TAB, CH_PLUS, CH_MINUS, CH_ZERO,
                 CH_LX, CH_UX, CH_NINE, CH_LF, CH_UA};
    str_q.delete();
    repeat ($urandom_range(0, 6)) begin
      if ($urandom_range(0, 1)) str_q.push_back(8'($urandom_range(1, 255)));
      else str_q.push_back(specials[$urandom_range(0, 9)]);
    end
  endtask

  initial begin
    logic [RADIX_W-1:0] radix_plan[10];
    int start;
    sb = new();
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    in_valid = 1'b0;
    in_char_code = '0;
    send_idle_max = 3;
    recv_idle_max = 3;
    pressure_req = 0;
    live_chars = 0;
    radix_plan = '{RADIX_DEC, RADIX_AUTO, RADIX_HEX, RADIX_OCT, 6'd2, 6'd1,
                   6'd36, 6'd63, 6'd17, 6'($urandom_range(0, 63))};
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset radix: empty string, blanks/sign/stop with trailing junk, lone sign.
    send_text("");
    send_text(" \t-12a9");
    send_text("+");
    set_radix(RADIX_AUTO);
    send_text("0");
    send_text("0x1F");
    send_text("-017");
    // Explicit hex does not skip the 0x prefix.
    set_radix(RADIX_HEX);
    send_text("0xff");
    set_radix(6'd1);
    send_text("01");
    set_radix(6'd63);
    send_text("Ff");
    send_text("Gz");

    foreach (radix_plan[p]) begin
      set_radix(radix_plan[p]);
      if (p == 1) pressure_req++;
      if (p == 3) begin
        send_idle_max = 0;
        recv_idle_max = 0;
      end else begin
        send_idle_max = 3;
        recv_idle_max = 3;
      end
      start = live_chars;
      while (live_chars - start < PHASE_CHARS) begin
        if ($urandom_range(0, 4) == 0) build_noise();
        else build_number(radix_plan[p]);
        send_str_q();
      end
    end

    drain_requests();
    repeat (10) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
